### sv/scle_pkg.sv
// ----------------------------------------------------------------------------
// Scancode line editor package
// Shared constants, codes and the scancode-to-ASCII table.
// ----------------------------------------------------------------------------
package scle_pkg;

    localparam int LINE_MAX   = 32;
    localparam int LEN_W      = $clog2(LINE_MAX);
    localparam int CHAR_W     = 7;
    localparam int PREFIX_LEN = 4;
    localparam int ECHO_START = 5;
    localparam int ECHO_LIMIT = 26;
    localparam int ECHO_END   = ECHO_START + ECHO_LIMIT;

    localparam logic [7:0] SC_ENTER     = 8'h1C;
    localparam logic [7:0] SC_BACKSPACE = 8'h0E;

    localparam logic [31:0] WORD_HELP = "help";
    localparam logic [31:0] WORD_ECHO = "echo";

    typedef enum logic [1:0] {
        KIND_TYPED = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_TEXT  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        CMD_HELP    = 2'd0,
        CMD_ECHO    = 2'd1,
        CMD_UNKNOWN = 2'd2,
        CMD_EMPTY   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP,
        ST_DONE,
        ST_ECHO_RD,
        ST_ECHO_WR
    } state_t;

    // Character i of a four-character word, first character in the top byte.
    function automatic logic [CHAR_W-1:0] word_char(input logic [31:0] w,
                                                    input logic [1:0] i);
        logic [7:0] c;
        unique case (i)
            2'd0: c = w[31:24];
            2'd1: c = w[23:16];
            2'd2: c = w[15:8];
            2'd3: c = w[7:0];
        endcase
        return c[CHAR_W-1:0];
    endfunction

    // Set 1 make code to ASCII; zero means the key is not mapped.
    function automatic logic [CHAR_W-1:0] map_scancode(input logic [7:0] sc);
        logic [7:0] c;
        case (sc)
            8'h02: c = "1";
            8'h03: c = "2";
            8'h04: c = "3";
            8'h05: c = "4";
            8'h06: c = "5";
            8'h07: c = "6";
            8'h08: c = "7";
            8'h09: c = "8";
            8'h0A: c = "9";
            8'h0B: c = "0";
            8'h10: c = "q";
            8'h11: c = "w";
            8'h12: c = "e";
            8'h13: c = "r";
            8'h14: c = "t";
            8'h15: c = "y";
            8'h16: c = "u";
            8'h17: c = "i";
            8'h18: c = "o";
            8'h19: c = "p";
            8'h1E: c = "a";
            8'h1F: c = "s";
            8'h20: c = "d";
            8'h21: c = "f";
            8'h22: c = "g";
            8'h23: c = "h";
            8'h24: c = "j";
            8'h25: c = "k";
            8'h26: c = "l";
            8'h2C: c = "z";
            8'h2D: c = "x";
            8'h2E: c = "c";
            8'h2F: c = "v";
            8'h30: c = "b";
            8'h31: c = "n";
            8'h32: c = "m";
            8'h39: c = " ";
            default: c = 8'h00;
        endcase
        return c[CHAR_W-1:0];
    endfunction

endpackage

### sv/scle_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module scle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### sv/scancode_line_editor_core.sv
// ----------------------------------------------------------------------------
// Scancode line editor core
// Set 1 scancodes in, echoed characters and command results out.
// ----------------------------------------------------------------------------
// A break code, an unmapped code, backspace or a typed character is taken
// in the idle state and gives at most one result. Enter on a line shorter
// than four characters answers at once; otherwise the first four characters
// are read back from the single-read-port line RAM before the line-done
// result, and for the echo command each text character then passes a RAM
// read state and an output load state. Input is held off until the last
// result of an Enter is loaded into the output register.
module scancode_line_editor_core
    import scle_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] scancode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [6:0] char_out, [8:7] command, rest zero
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast
);

    state_t             state_reg, state_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [2:0]         cnt_reg, cnt_next;
    logic               help_reg, help_next;
    logic               echo_reg, echo_next;
    logic [LEN_W-1:0]   pos_reg, pos_next;
    logic [LEN_W-1:0]   end_reg, end_next;

    logic               out_valid_reg;
    kind_t              out_kind_reg;
    logic [CHAR_W-1:0]  out_char_reg;
    cmd_t               out_cmd_reg;
    logic               out_last_reg;

    logic               out_free;
    logic               emit;
    kind_t              emit_kind;
    logic [CHAR_W-1:0]  emit_char;
    cmd_t               emit_cmd;
    logic               emit_last;

    logic               wr_en;
    logic [CHAR_W-1:0]  wr_data;
    logic [LEN_W-1:0]   rd_addr;
    logic [CHAR_W-1:0]  rd_data;

    logic [CHAR_W-1:0]  mapped;
    logic [1:0]         cmp_idx;
    cmd_t               cmd_sel;

    scle_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (LINE_MAX)
    ) u_line_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (len_reg),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign out_free = !out_valid_reg || m_tready;
    assign mapped   = map_scancode(s_tdata);
    assign cmp_idx  = 2'(cnt_reg - 3'd1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            out_valid_reg <= emit || (out_valid_reg && !m_tready);
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg  <= cnt_next;
        help_reg <= help_next;
        echo_reg <= echo_next;
        pos_reg  <= pos_next;
        end_reg  <= end_next;
        if (emit) begin
            out_kind_reg <= emit_kind;
            out_char_reg <= emit_char;
            out_cmd_reg  <= emit_cmd;
            out_last_reg <= emit_last;
        end
    end

    always_comb begin
        state_next = state_reg;
        len_next   = len_reg;
        cnt_next   = cnt_reg;
        help_next  = help_reg;
        echo_next  = echo_reg;
        pos_next   = pos_reg;
        end_next   = end_reg;
        emit       = 1'b0;
        emit_kind  = KIND_TYPED;
        emit_char  = '0;
        emit_cmd   = CMD_HELP;
        emit_last  = 1'b1;
        wr_en      = 1'b0;
        wr_data    = mapped;
        rd_addr    = pos_reg;
        s_tready   = 1'b0;
        cmd_sel    = help_reg ? CMD_HELP : (echo_reg ? CMD_ECHO : CMD_UNKNOWN);

        unique case (state_reg)
            ST_IDLE: begin
                s_tready = out_free;
                if (s_tvalid && out_free) begin
                    priority if (s_tdata[7]) begin
                        // Key release: nothing to do.
                    end else if (s_tdata == SC_ENTER) begin
                        if (len_reg == '0) begin
                            emit      = 1'b1;
                            emit_kind = KIND_DONE;
                            emit_cmd  = CMD_EMPTY;
                        end else if (32'(len_reg) < PREFIX_LEN) begin
                            emit      = 1'b1;
                            emit_kind = KIND_DONE;
                            emit_cmd  = CMD_UNKNOWN;
                            len_next  = '0;
                        end else begin
                            cnt_next   = '0;
                            help_next  = 1'b1;
                            echo_next  = 1'b1;
                            state_next = ST_CMP;
                        end
                    end else if (s_tdata == SC_BACKSPACE) begin
                        if (len_reg != '0) begin
                            len_next = len_reg - 1'b1;
                        end
                    end else if (mapped != '0 && 32'(len_reg) < LINE_MAX - 1) begin
                        wr_en     = 1'b1;
                        emit      = 1'b1;
                        emit_kind = KIND_TYPED;
                        emit_char = mapped;
                        len_next  = len_reg + 1'b1;
                    end
                end
            end

            ST_CMP: begin
                // Reads of positions 0..3 are issued in the cycle before their compare.
                rd_addr  = LEN_W'(cnt_reg[1:0]);
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg != '0) begin
                    help_next = help_reg && (rd_data == word_char(WORD_HELP, cmp_idx));
                    echo_next = echo_reg && (rd_data == word_char(WORD_ECHO, cmp_idx));
                end
                if (32'(cnt_reg) == PREFIX_LEN) begin
                    state_next = ST_DONE;
                end
            end

            ST_DONE: begin
                if (out_free) begin
                    emit      = 1'b1;
                    emit_kind = KIND_DONE;
                    emit_cmd  = cmd_sel;
                    if (cmd_sel == CMD_ECHO && 32'(len_reg) > ECHO_START) begin
                        emit_last  = 1'b0;
                        pos_next   = LEN_W'(ECHO_START);
                        end_next   = (32'(len_reg) > ECHO_END) ? LEN_W'(ECHO_END) : len_reg;
                        state_next = ST_ECHO_RD;
                    end else begin
                        len_next   = '0;
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_ECHO_RD: begin
                state_next = ST_ECHO_WR;
            end

            ST_ECHO_WR: begin
                // The read address is held, so the RAM output stays put while stalled.
                if (out_free) begin
                    emit      = 1'b1;
                    emit_kind = KIND_TEXT;
                    emit_char = rd_data;
                    emit_last = (pos_reg + 1'b1 == end_reg);
                    if (pos_reg + 1'b1 == end_reg) begin
                        len_next   = '0;
                        state_next = ST_IDLE;
                    end else begin
                        pos_next   = pos_reg + 1'b1;
                        state_next = ST_ECHO_RD;
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_cmd_reg, out_char_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    // The line never grows past one short of the store size.
    assert property (@(posedge aclk) disable iff (!aresetn)
        32'(len_reg) <= LINE_MAX - 1)
        else $error("line length beyond store size");

    // A line-done that is not last must be followed by echo text readout.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && emit_kind == KIND_DONE && !emit_last) |=> state_reg == ST_ECHO_RD)
        else $error("line done without echo readout");

    // The final result of an Enter leaves an empty line.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && emit_last && (emit_kind == KIND_DONE || emit_kind == KIND_TEXT))
        |=> len_reg == '0)
        else $error("line not cleared after Enter");

    // No new request is taken while an Enter is still being worked off.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_tready)
        else $error("request taken during command processing");

endmodule
